FILE: design/lsa_pkg.sv
package lsa_pkg;

  localparam int LSA_STACK_DEPTH = 256;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // marks "no even value held"; odd, so never a held even value
  localparam logic signed [31:0] NO_EVEN = -32'sd1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic        [1:0]  status;
    logic        [8:0]  entry_count;
    logic signed [31:0] total_sum;
    logic signed [31:0] largest;
    logic               largest_valid;
    logic signed [31:0] smallest_even;
  } out_word_t;

  typedef struct packed {
    logic start;   // latch the input word and issue the store read
    logic finish;  // apply the operation and load the output register
  } lsa_cmd_t;

endpackage

FILE: design/lifo_stack_with_aggregates_top.sv
// Bounded LIFO stack of signed 32-bit values with running aggregates.
//
// Input channel (in_valid/in_ready/in_word): one word is a push of
// push_value or a pop of the top value. Output channel
// (out_valid/out_ready/out_word): exactly one word per input word, in order,
// carrying the popped value, a status (ok, push dropped on full, pop on
// empty) and the count, wrapping sum, largest value and least even value of
// the contents after the operation.
//
// For each input word, the accept cycle latches the word and issues the read
// of the store's top entry; the execute state then applies the operation and
// loads the output register, raising out_valid. No new input word is taken
// until the execute state is done, as the store has a registered read port.
// Every level of the store keeps the maximum and least even value of the
// levels below it, so a pop restores the aggregates from one read instead
// of a walk over the contents.
//
// Reset empties the stack at once (no clearing pass). When the receiver
// stalls, the result holds in the output register, one more input word is
// still taken, and its operation waits until the output register drains.
module lifo_stack_with_aggregates_top
  import lsa_pkg::*;
#(
  parameter int STACK_DEPTH = LSA_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  lsa_cmd_t cmd;

  // sequence accept, execute and output handoff
  lsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // hold the store, the running aggregates and the output register
  lsa_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule

FILE: design/lsa_ctrl.sv
module lsa_ctrl
  import lsa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lsa_cmd_t cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  assign in_ready   = (state == S_IDLE);
  assign cmd.start  = (state == S_IDLE) && in_valid;
  // hold the finished operation until the output register is free
  assign cmd.finish = (state == S_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          if (cmd.finish) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/lsa_datapath.sv
module lsa_datapath
  import lsa_pkg::*;
#(
  parameter int STACK_DEPTH = LSA_STACK_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  lsa_cmd_t  cmd,
  input  in_word_t  in_word,
  output out_word_t out_word
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // each level keeps its value and the aggregates of the levels below it
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prev_max;
    logic signed [31:0] prev_even;
  } entry_t;

  entry_t mem [STACK_DEPTH];
  entry_t rdata;

  logic               op;
  logic signed [31:0] val;
  logic [CW-1:0]      count;
  logic signed [31:0] sum;
  logic signed [31:0] cur_max;
  logic signed [31:0] cur_even;

  logic [CW-1:0]      count_next;
  logic signed [31:0] sum_next;
  logic signed [31:0] cur_max_next;
  logic signed [31:0] cur_even_next;
  logic signed [31:0] popped_next;
  logic [1:0]         status_next;
  logic               wr_en;
  logic [CW-1:0]      rd_addr;
  logic [CW+8:0]      count_ext;

  assign rd_addr = count - CW'(1);

  always_comb begin
    count_next    = count;
    sum_next      = sum;
    cur_max_next  = cur_max;
    cur_even_next = cur_even;
    popped_next   = '0;
    status_next   = ST_OK;
    wr_en         = 1'b0;
    if (op == OP_PUSH) begin
      if (count == CW'(STACK_DEPTH)) begin
        status_next = ST_FULL;
      end else begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
        sum_next   = sum + val;
        if (count == '0 || val > cur_max) begin
          cur_max_next = val;
        end
        if (!val[0] && (cur_even == NO_EVEN || val < cur_even)) begin
          cur_even_next = val;
        end
      end
    end else begin
      if (count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        count_next    = count - CW'(1);
        popped_next   = rdata.value;
        sum_next      = sum - rdata.value;
        cur_max_next  = rdata.prev_max;
        cur_even_next = rdata.prev_even;
      end
    end
  end

  assign count_ext = {9'd0, count_next};

  always_ff @(posedge clk) begin
    if (wr_en && cmd.finish) begin
      mem[count[AW-1:0]] <= '{value: val, prev_max: cur_max, prev_even: cur_even};
    end
    if (cmd.start) begin
      rdata <= mem[rd_addr[AW-1:0]];
      op    <= in_word.op;
      val   <= in_word.push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum      <= '0;
      cur_max  <= '0;
      cur_even <= NO_EVEN;
    end else if (cmd.finish) begin
      count    <= count_next;
      sum      <= sum_next;
      cur_max  <= cur_max_next;
      cur_even <= cur_even_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_word.popped_value  <= popped_next;
      out_word.status        <= status_next;
      out_word.entry_count   <= count_ext[8:0];
      out_word.total_sum     <= sum_next;
      out_word.largest       <= (count_next == '0) ? 32'sd0 : cur_max_next;
      out_word.largest_valid <= (count_next != '0);
      out_word.smallest_even <= (count_next == '0) ? NO_EVEN : cur_even_next;
    end
  end

endmodule
